[hw/rtl/sbsh_pkg.sv]
// shared types, constants and round functions of the sha-256 byte stream hasher
// used by sbsh_ctrl, sbsh_dp and the top level; no dependencies
`default_nettype none

package sbsh_pkg;

    localparam int NumRounds  = 64;
    localparam int NumWords   = 8;
    localparam int BlockBytes = 64;
    localparam int LenStart   = 56;

    localparam logic [5:0] RoundLast = 6'(NumRounds - 1);
    localparam logic [5:0] FillLast  = 6'(BlockBytes - 1);
    localparam logic [5:0] FillLen   = 6'(LenStart);
    localparam logic [2:0] WordLast  = 3'(NumWords - 1);
    localparam logic [7:0] PadFirst  = 8'h80;

    localparam logic [31:0] InitHash [NumWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PAD   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_FOLD  = 4'b1000
    } t_state;

    typedef struct packed {
        logic       absorb;
        logic       pad;
        logic       load;
        logic       round;
        logic [5:0] rnd_idx;
        logic       fold;
        logic       last_blk;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic len_ok;
        logic out_busy;
    } t_stat;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sbsh_dp.sv]
// datapath: message window, working variables, hash state, padding and digest buffer
// depends on sbsh_pkg; driven by sbsh_ctrl commands
`default_nettype none

module sbsh_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sbsh_pkg::t_cmd i_cmd,
    input  wire logic [7:0]     i_byte,
    output sbsh_pkg::t_stat     o_stat,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_out_word,
    output logic [2:0]          o_out_index,
    output logic                o_out_last
);
    import sbsh_pkg::*;

    logic [511:0] r_win;
    logic [31:0]  r_wk   [NumWords];
    logic [31:0]  r_hash [NumWords];
    logic [31:0]  r_obuf [NumWords];
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic         r_first;
    logic         r_len_ok;
    logic [2:0]   r_ocnt;
    logic         r_ovalid;

    logic [7:0]  pad_byte;
    logic [7:0]  in_byte;
    logic        shift_en;
    logic        len_byte;
    logic [31:0] w0, w1, w9, w14;
    logic [31:0] w_new;
    logic [31:0] t1, t2;
    logic [31:0] sum [NumWords];

    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];

    assign len_byte = r_len_ok && (r_fill >= FillLen);
    assign shift_en = i_cmd.absorb || i_cmd.pad;

    always_comb begin
        if (r_first) begin
            pad_byte = PadFirst;
        end else if (len_byte) begin
            pad_byte = r_bits[63:56];
        end else begin
            pad_byte = 8'h00;
        end
        in_byte = i_cmd.absorb ? i_byte : pad_byte;
    end

    assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
    assign t1 = r_wk[7] + bsig1(r_wk[4]) + choose(r_wk[4], r_wk[5], r_wk[6])
              + RoundK[i_cmd.rnd_idx] + w0;
    assign t2 = bsig0(r_wk[0]) + major(r_wk[0], r_wk[1], r_wk[2]);

    always_comb begin
        for (int i = 0; i < NumWords; i++) begin
            sum[i] = r_hash[i] + r_wk[i];
        end
    end

    // window and working variables
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_win <= {r_win[503:0], in_byte};
        end else if (i_cmd.round) begin
            r_win <= {r_win[479:0], w_new};
        end
        if (i_cmd.load) begin
            r_wk <= r_hash;
        end else if (i_cmd.round) begin
            r_wk[0] <= t1 + t2;
            r_wk[1] <= r_wk[0];
            r_wk[2] <= r_wk[1];
            r_wk[3] <= r_wk[2];
            r_wk[4] <= r_wk[3] + t1;
            r_wk[5] <= r_wk[4];
            r_wk[6] <= r_wk[5];
            r_wk[7] <= r_wk[6];
        end
        if (i_cmd.fold && i_cmd.last_blk) begin
            r_obuf <= sum;
        end
    end

    // hash state, fill and length tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= InitHash;
            r_fill   <= '0;
            r_bits   <= '0;
            r_first  <= 1'b1;
            r_len_ok <= 1'b0;
        end else begin
            if (shift_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.absorb) begin
                r_bits <= r_bits + 64'd8;
            end else if (i_cmd.pad) begin
                r_first <= 1'b0;
                if (r_fill < FillLen) begin
                    r_len_ok <= 1'b1;
                end
                if (len_byte) begin
                    r_bits <= {r_bits[55:0], 8'h00};
                end
            end
            if (i_cmd.fold) begin
                if (i_cmd.last_blk) begin
                    r_hash   <= InitHash;
                    r_bits   <= '0;
                    r_first  <= 1'b1;
                    r_len_ok <= 1'b0;
                end else begin
                    r_hash <= sum;
                end
            end
        end
    end

    // digest output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_ocnt   <= '0;
        end else if (i_cmd.fold && i_cmd.last_blk) begin
            r_ovalid <= 1'b1;
            r_ocnt   <= '0;
        end else if (r_ovalid && i_out_ready) begin
            r_ocnt <= r_ocnt + 3'd1;
            if (r_ocnt == WordLast) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_obuf[r_ocnt];
    assign o_out_index = r_ocnt;
    assign o_out_last  = (r_ocnt == WordLast);

    assign o_stat.fill_last = (r_fill == FillLast);
    assign o_stat.len_ok    = r_len_ok;
    assign o_stat.out_busy  = r_ovalid;

endmodule

`default_nettype wire

[hw/rtl/sbsh_ctrl.sv]
// controller: sequences absorb, padding, rounds and fold of the hasher
// depends on sbsh_pkg; commands sbsh_dp
`default_nettype none

module sbsh_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_present,
    input  wire logic            i_finish,
    output logic                 o_ready,
    input  wire sbsh_pkg::t_stat i_stat,
    output sbsh_pkg::t_cmd       o_cmd
);
    import sbsh_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_rnd, n_rnd;
    logic       r_fin, n_fin;
    logic       r_pad, n_pad;
    logic       req;

    assign o_ready = i_rst_n && (r_state == ST_IDLE);
    assign req     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_fin   = r_fin;
        n_pad   = r_pad;
        o_cmd   = '0;
        o_cmd.rnd_idx = r_rnd;
        case (r_state)
            ST_IDLE: begin
                if (req) begin
                    o_cmd.absorb = i_present;
                    if (i_present && i_stat.fill_last) begin
                        o_cmd.load = 1'b1;
                        n_rnd      = '0;
                        n_fin      = i_finish;
                        n_state    = ST_ROUND;
                    end else if (i_finish) begin
                        n_pad   = 1'b1;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.pad = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = '0;
                    n_state    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == RoundLast) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_pad && i_stat.len_ok) begin
                    // last block of the message waits for the digest buffer
                    if (!i_stat.out_busy) begin
                        o_cmd.fold     = 1'b1;
                        o_cmd.last_blk = 1'b1;
                        n_pad          = 1'b0;
                        n_fin          = 1'b0;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.fold = 1'b1;
                    if (r_pad || r_fin) begin
                        n_pad   = 1'b1;
                        n_fin   = 1'b0;
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_pad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_fin   <= n_fin;
            r_pad   <= n_pad;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sha256_byte_stream_hasher.sv]
// top level of the sha-256 byte stream hasher: controller plus datapath
// depends on sbsh_pkg, sbsh_ctrl and sbsh_dp
//
// channel   dir  tdata             tuser            tlast
// s_axis    in   [7:0] data_byte   [0] byte_present finish
// m_axis    out  [31:0] digest_word [2:0] word_index last_word
//
// requests are taken while idle; the 64th byte of a block starts the round
// loop of 64 rounds, one round a cycle, then one fold, input stalled; a
// finish shifts padding and length in one byte a cycle and compresses one
// or two blocks; digest words leave from their own buffer, so the next message
// is taken while they drain; a last block waits for that buffer
// reset is synchronous, active low, and leaves the initial hash state loaded
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic [0:0]  i_s_axis_tuser,   // byte_present
    input  wire logic        i_s_axis_tlast,   // finish
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // digest_word
    output logic [2:0]       o_m_axis_tuser,   // word_index
    output logic             o_m_axis_tlast    // last_word
);
    import sbsh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sbsh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_present (i_s_axis_tuser[0]),
        .i_finish  (i_s_axis_tlast),
        .o_ready   (o_s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    sbsh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_byte      (i_s_axis_tdata),
        .o_stat      (stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_word  (o_m_axis_tdata),
        .o_out_index (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[tb/sv/sbsh_digest_checker.sv]
// digest checker for the sha-256 byte stream hasher: watches both stream channels,
// keeps its own sha-256 state to predict every digest word and compares in order
// standalone, no package needed
`default_nettype none

module sbsh_digest_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // data_byte
    input  wire logic [0:0]  i_s_tuser,   // byte_present
    input  wire logic        i_s_tlast,   // finish
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // digest_word
    input  wire logic [2:0]  i_m_tuser,   // word_index
    input  wire logic        i_m_tlast,   // last_word
    output int               o_fail_count,
    output int               o_words_due,
    output int               o_digests,
    output int               o_words_checked
);

    localparam logic [7:0] PadMark = 8'h80;
    localparam int         LenPos  = 56;
    localparam int         BlkLen  = 64;

    localparam logic [31:0] HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ShaK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last_flag;
    } t_digest_word;

    logic [31:0]  hash_st [8];
    logic [7:0]   blk [BlkLen];
    int unsigned  fill;
    logic [63:0]  msg_bits;
    t_digest_word digest_due [$];

    initial begin
        o_fail_count    = 0;
        o_words_due     = 0;
        o_digests       = 0;
        o_words_checked = 0;
        for (int i = 0; i < BlkLen; i++) blk[i] = 8'h00;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_st[i] = HashInit[i];
        fill     = 0;
        msg_bits = 64'd0;
    endtask

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
        e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ShaK[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
        hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    endtask

    // pad, append the bit length, and queue the eight digest words
    task automatic close_message();
        logic [63:0]  total;
        t_digest_word ent;
        total = msg_bits + 64'(fill) * 64'd8;
        blk[fill] = PadMark;
        fill++;
        if (fill > LenPos) begin
            while (fill < BlkLen) begin
                blk[fill] = 8'h00;
                fill++;
            end
            compress_blk();
            fill = 0;
        end
        while (fill < LenPos) begin
            blk[fill] = 8'h00;
            fill++;
        end
        for (int i = 0; i < 8; i++) blk[LenPos + i] = total[63 - 8*i -: 8];
        compress_blk();
        for (int i = 0; i < 8; i++) begin
            ent.digest    = hash_st[i];
            ent.index     = 3'(i);
            ent.last_flag = (i == 7);
            digest_due = {digest_due, ent};
        end
        o_digests++;
        restart_message();
    endtask

    task automatic take_request(input logic [7:0] b, input logic p, input logic f);
        if (p) begin
            blk[fill] = b;
            fill++;
            if (fill == BlkLen) begin
                compress_blk();
                msg_bits += 64'd512;
                fill = 0;
            end
        end
        if (f) close_message();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("digest check: %s got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic check_word();
        t_digest_word ent;
        if (digest_due.size() == 0) begin
            report_mismatch("word with none pending", i_m_tdata, 32'h0);
        end else begin
            ent = digest_due.pop_front();
            o_words_checked++;
            if (i_m_tdata !== ent.digest)
                report_mismatch("digest_word", i_m_tdata, ent.digest);
            if (i_m_tuser !== ent.index)
                report_mismatch("word_index", 32'(i_m_tuser), 32'(ent.index));
            if (i_m_tlast !== ent.last_flag)
                report_mismatch("last_word", 32'(i_m_tlast), 32'(ent.last_flag));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
        end else begin
            if (i_s_tvalid && i_s_tready)
                take_request(i_s_tdata, i_s_tuser[0], i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_word();
        end
        o_words_due = digest_due.size();
    end

endmodule

`default_nettype wire

[tb/sv/tb_sha256_byte_stream_hasher.sv]
// top of the sha-256 byte stream hasher testbench: clock, reset, request stimulus,
// random output stalls and the verdict
// depends on sha256_byte_stream_hasher and sbsh_digest_checker
`default_nettype none

module tb_sha256_byte_stream_hasher;

    localparam int RandRequests = 180;
    localparam int StartHold    = 1500;
    localparam int DrainCycles  = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int words_due;
    int digests;
    int words_checked;
    int requests_sent = 0;
    int bytes_sent = 0;

    sha256_byte_stream_hasher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    sbsh_digest_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due),
        .o_digests       (digests),
        .o_words_checked (words_checked)
    );

    always #5 i_clk = ~i_clk;

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return 0;
        else if (r < 16) return $urandom_range(1, 3);
        else if (r < 19) return $urandom_range(4, 15);
        else return $urandom_range(40, 200);
    endfunction

    // called at a clock edge, returns at the edge where the request was taken
    task automatic send_request(input logic [7:0] b, input logic p, input logic f);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser[0] <= p;
        s_tlast    <= f;
        do @(posedge i_clk); while (!s_tready);
        if (p || f) requests_sent++;
        if (p) bytes_sent++;
    endtask

    task automatic send_message(input int len, input logic join_finish);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
            b = 8'($urandom);
            send_request(b, 1'b1, join_finish && (k == len - 1));
        end
        if (len == 0 || !join_finish) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        int boundary [4];
        boundary = '{55, 56, 63, 64};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, with ignored data on the finish request
        send_request(8'hff, 1'b0, 1'b1);
        // no byte and no finish
        send_request(8'ha5, 1'b0, 1'b0);
        // "abc" with the finish on the last byte
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7f, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'h01, 1'b1, 1'b1);
        // back-to-back empty messages fill the digest buffer
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);

        // one message at a padding boundary, then mostly short ones
        send_message(boundary[$urandom_range(0, 3)], 1'($urandom));
        while (requests_sent < RandRequests) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(11, 70);
            send_message(len, 1'($urandom));
        end
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("covered %0d requests carrying %0d bytes; %0d digests, %0d words compared",
                 requests_sent, bytes_sent, digests, words_checked);
        if (fail_count == 0 && words_due == 0) begin
            $display("sha256_byte_stream_hasher: match");
        end else begin
            $display("sha256_byte_stream_hasher: mismatch");
        end
        $finish;
    end

    // output side: long hold-off first so the block backs up, then random stalls
    initial begin
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        for (hold = 0; hold < StartHold; hold++) @(posedge i_clk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            m_tready <= 1'b0;
            hold = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 300)
                                                : $urandom_range(1, 4);
            repeat (hold) @(posedge i_clk);
        end
    end

    initial begin
        #50000000;
        $display("timeout waiting on the block");
        $display("sha256_byte_stream_hasher: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
